### src/pia_pkg.sv
// Package: sizes, item type, arctangent table and angle wrap for the winding-angle test.
package pia_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int SUM_BITS     = ANGLE_BITS + 8;
  localparam int CW           = COORD_BITS + 4;
  localparam int TOL_BITS     = 15;
  localparam int ATAN_DEPTH   = 24;
  localparam int STEP_BITS    = $clog2(ATAN_DEPTH);

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(10);
  localparam logic [31:0]         HALF_TURN32 = 32'h8000_0000;
  localparam logic [31:0]         BEARING_ROUND = 32'd1 << (31 - ANGLE_BITS);

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 same;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } pia_item_t;

  typedef struct packed {
    logic pend_valid;
    logic retire;
  } pia_acc_status_t;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // a - b wrapped to (-half, +half], sign-extended to the sum width
  function automatic logic [SUM_BITS-1:0] wrap_diff(input logic [ANGLE_BITS-1:0] a,
                                                    input logic [ANGLE_BITS-1:0] b);
    logic [ANGLE_BITS-1:0] d;
    d = a - b;
    if (d == {1'b1, {(ANGLE_BITS-1){1'b0}}}) begin
      return {{(SUM_BITS-ANGLE_BITS){1'b0}}, d};
    end
    return {{(SUM_BITS-ANGLE_BITS){d[ANGLE_BITS-1]}}, d};
  endfunction

endpackage

### src/pia_cordic_cell.sv
// One CORDIC vectoring iteration cell, registered, passing its item to the next cell.
module pia_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pia_pkg::STEP_BITS-1:0] step,
  input  pia_pkg::pia_item_t            in_item,
  output pia_pkg::pia_item_t            out_item
);

  logic signed [pia_pkg::CW-1:0] xs;
  logic signed [pia_pkg::CW-1:0] ys;
  logic [31:0]                   ang;

  always_comb begin
    xs  = in_item.x >>> step;
    ys  = in_item.y >>> step;
    ang = pia_pkg::ATAN_TURN32[step];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= in_item.valid;
    end
    out_item.last <= in_item.last;
    out_item.same <= in_item.same;
    if (in_item.y < 0) begin
      out_item.x <= in_item.x - ys;
      out_item.y <= in_item.y + xs;
      out_item.z <= in_item.z - ang;
    end else begin
      out_item.x <= in_item.x + ys;
      out_item.y <= in_item.y - xs;
      out_item.z <= in_item.z + ang;
    end
  end

endmodule

### src/pia_accum.sv
// Bearing rounding, angle-sum accumulation, polygon close and result register.
module pia_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  pia_pkg::pia_item_t           tail,
  input  logic [pia_pkg::TOL_BITS-1:0] tol,
  input  logic                         out_stall,
  output pia_pkg::pia_acc_status_t     status,
  output logic                         out_valid,
  output logic                         inside_res,
  output logic                         on_vertex
);

  logic                            pend_valid;
  logic                            pend_last;
  logic                            pend_same;
  logic [pia_pkg::ANGLE_BITS-1:0]  pend_b;

  logic [pia_pkg::ANGLE_BITS-1:0]  first_bearing;
  logic [pia_pkg::ANGLE_BITS-1:0]  previous_bearing;
  logic [pia_pkg::SUM_BITS-1:0]    bearing_sum;
  logic                            hit_vertex;
  logic                            mid_polygon;

  logic [31:0]                     z_round;
  logic                            retire;
  logic [pia_pkg::ANGLE_BITS-1:0]  first_next;
  logic [pia_pkg::SUM_BITS-1:0]    sum_next;
  logic [pia_pkg::SUM_BITS-1:0]    sum_close;
  logic [pia_pkg::SUM_BITS-1:0]    mag;
  logic                            hit_next;
  logic                            inside_next;

  always_comb begin
    z_round = tail.z + pia_pkg::BEARING_ROUND;
    retire  = pend_valid && (!pend_last || !out_valid || !out_stall);
    if (mid_polygon) begin
      first_next = first_bearing;
      sum_next   = bearing_sum + pia_pkg::wrap_diff(previous_bearing, pend_b);
      hit_next   = hit_vertex | pend_same;
    end else begin
      first_next = pend_b;
      sum_next   = '0;
      hit_next   = pend_same;
    end
    sum_close   = sum_next + pia_pkg::wrap_diff(pend_b, first_next);
    mag         = sum_close[pia_pkg::SUM_BITS-1] ? (-sum_close) : sum_close;
    inside_next = mag >= pia_pkg::SUM_BITS'(tol);
    status.pend_valid = pend_valid;
    status.retire     = retire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (tail.valid) begin
      pend_valid <= 1'b1;
    end else if (retire) begin
      pend_valid <= 1'b0;
    end
    if (tail.valid) begin
      pend_last <= tail.last;
      pend_same <= tail.same;
      pend_b    <= z_round[31 -: pia_pkg::ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_bearing    <= '0;
      previous_bearing <= '0;
      bearing_sum      <= '0;
      hit_vertex       <= 1'b0;
      mid_polygon      <= 1'b0;
    end else if (retire) begin
      first_bearing    <= first_next;
      previous_bearing <= pend_b;
      bearing_sum      <= pend_last ? sum_close : sum_next;
      hit_vertex       <= hit_next;
      mid_polygon      <= !pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire && pend_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (retire && pend_last) begin
      inside_res <= !hit_next && inside_next;
      on_vertex  <= hit_next;
    end
  end

endmodule

### src/point_in_polygon_winding_angle.sv
// Top level: winding-angle point-in-polygon test, one vertex per transfer.
// Path: input register, one CORDIC cell per iteration, accumulate register, result register.
// A new vertex is taken only once the chain is empty and the accumulate register is retiring
// or free, so there is one item in flight.
// A waiting result stalls the accumulate stage only when a new closing vertex reaches it.
// Reset (rst, synchronous): empties the chain, clears the polygon state, tolerance to 10.
module point_in_polygon_winding_angle (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [pia_pkg::TOL_BITS-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pia_pkg::COORD_BITS-1:0] query_x,
  input  logic signed [pia_pkg::COORD_BITS-1:0] query_y,
  input  logic signed [pia_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pia_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                  last_vertex,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  inside_res,
  output logic                                  on_vertex
);

  pia_pkg::pia_item_t              chain [pia_pkg::CORDIC_STEPS+1];
  pia_pkg::pia_acc_status_t        status;
  logic [pia_pkg::TOL_BITS-1:0]    angle_tolerance;
  logic                            accept;
  logic                            chain_busy;
  logic [pia_pkg::CORDIC_STEPS+1:0] valid_vec;
  logic signed [pia_pkg::COORD_BITS:0] dx;
  logic signed [pia_pkg::COORD_BITS:0] dy;
  logic signed [pia_pkg::CW-1:0]   xe;
  logic signed [pia_pkg::CW-1:0]   ye;

  always_comb begin
    chain_busy = 1'b0;
    for (int k = 0; k <= pia_pkg::CORDIC_STEPS; k++) begin
      chain_busy = chain_busy | chain[k].valid;
      valid_vec[k] = chain[k].valid;
    end
    valid_vec[pia_pkg::CORDIC_STEPS+1] = status.pend_valid;
    in_stall = chain_busy || (status.pend_valid && !status.retire);
    accept   = in_valid && !in_stall;
    dx = $signed({vertex_x[pia_pkg::COORD_BITS-1], vertex_x})
       - $signed({query_x[pia_pkg::COORD_BITS-1], query_x});
    dy = $signed({vertex_y[pia_pkg::COORD_BITS-1], vertex_y})
       - $signed({query_y[pia_pkg::COORD_BITS-1], query_y});
    xe = pia_pkg::CW'(dx);
    ye = pia_pkg::CW'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tolerance <= pia_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      angle_tolerance <= cfg_wr_data;
    end
  end

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= accept;
    end
    chain[0].last <= last_vertex;
    chain[0].same <= (query_x == vertex_x) && (query_y == vertex_y);
    if (dx < 0) begin
      chain[0].x <= -xe;
      chain[0].y <= -ye;
      chain[0].z <= pia_pkg::HALF_TURN32;
    end else begin
      chain[0].x <= xe;
      chain[0].y <= ye;
      chain[0].z <= '0;
    end
  end

  for (genvar i = 0; i < pia_pkg::CORDIC_STEPS; i++) begin : g_cell
    pia_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (pia_pkg::STEP_BITS'(i)),
      .in_item  (chain[i]),
      .out_item (chain[i+1])
    );
  end

  pia_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .tail       (chain[pia_pkg::CORDIC_STEPS]),
    .tol        (angle_tolerance),
    .out_stall  (out_stall),
    .status     (status),
    .out_valid  (out_valid),
    .inside_res (inside_res),
    .on_vertex  (on_vertex)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) $onehot0(valid_vec))
    else $error("more than one vertex in flight");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst) accept |=> chain[0].valid)
    else $error("accepted vertex did not enter the chain");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(inside_res && on_vertex))
    else $error("inside reported on a vertex hit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res) && $stable(on_vertex))
    else $error("stalled result changed");

endmodule

### sim/point_in_polygon_winding_angle_test.sv
`timescale 1ns / 100ps
// Testbench: winding-angle point-in-polygon block, directed table then random polygons vs predictor.
module point_in_polygon_winding_angle_test;
  localparam int COORD_BITS = pia_pkg::COORD_BITS;
  localparam int ANGLE_BITS = pia_pkg::ANGLE_BITS;
  localparam int CORDIC_STEPS = pia_pkg::CORDIC_STEPS;
  localparam int SUM_BITS = pia_pkg::SUM_BITS;
  localparam int TOL_BITS = pia_pkg::TOL_BITS;
  localparam logic [TOL_BITS-1:0] TOL_RESET = pia_pkg::TOL_RESET;

  localparam int LATENCY = CORDIC_STEPS + 2;
  localparam int SETTLE = LATENCY + 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_PCT = 11;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam real PI = 3.14159265358979;

  // atan(2^-i) scaled so a full turn is 2^32
  localparam logic [31:0] ATAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic                         last;
  } vertex_t;

  typedef struct packed {
    logic in_poly;
    logic on_vtx;
  } verdict_t;

  typedef struct {
    vertex_t  v;
    bit       typed;
    verdict_t want;
  } plan_row_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [TOL_BITS-1:0]          cfg_wr_data;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;
  logic                         out_valid;
  logic                         out_stall;
  logic                         inside_res;
  logic                         on_vertex;

  // polygon tracker state
  logic [TOL_BITS-1:0]   tol_model = TOL_RESET;
  logic [ANGLE_BITS-1:0] first_brg = '0;
  logic [ANGLE_BITS-1:0] prev_brg = '0;
  logic [SUM_BITS-1:0]   turn_sum = '0;
  logic                  touched = 1'b0;
  logic                  open_poly = 1'b0;

  verdict_t  verdicts_due[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        items_sent = 0;
  int        cycles_quiet = 0;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;

  point_in_polygon_winding_angle dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .query_x     (query_x),
    .query_y     (query_y),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inside_res  (inside_res),
    .on_vertex   (on_vertex)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // CORDIC vectoring, rounded to a binary angle
  function automatic logic [ANGLE_BITS-1:0] bearing_of(input longint dx, input longint dy);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    int          i;
    x = dx;
    y = dy;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end
    end
    z = z + (32'd1 << (31 - ANGLE_BITS));
    return z[31 -: ANGLE_BITS];
  endfunction

  // a - b folded into (-half, +half], sign-extended to the sum width
  function automatic logic [SUM_BITS-1:0] angle_step(input logic [ANGLE_BITS-1:0] a,
                                                      input logic [ANGLE_BITS-1:0] b);
    logic [ANGLE_BITS-1:0] d;
    longint                dd;
    d = a - b;
    dd = longint'(d);
    if (dd > (64'sd1 << (ANGLE_BITS - 1)))
      dd = dd - (64'sd1 << ANGLE_BITS);
    return dd[SUM_BITS-1:0];
  endfunction

  function automatic void fold_vertex(input vertex_t v, output bit closed, output verdict_t res);
    logic [ANGLE_BITS-1:0] b;
    logic [SUM_BITS-1:0]   mag;
    bit                    same;
    same = (v.qx == v.vx) && (v.qy == v.vy);
    b = bearing_of(longint'(v.vx) - longint'(v.qx), longint'(v.vy) - longint'(v.qy));
    if (!open_poly) begin
      first_brg = b;
      turn_sum = '0;
      touched = same;
    end else begin
      turn_sum = turn_sum + angle_step(prev_brg, b);
      touched = touched | same;
    end
    prev_brg = b;
    closed = v.last;
    res = '0;
    if (!v.last) begin
      open_poly = 1'b1;
      return;
    end
    turn_sum = turn_sum + angle_step(b, first_brg);
    mag = turn_sum[SUM_BITS-1] ? -turn_sum : turn_sum;
    res.on_vtx = touched;
    res.in_poly = !touched && (mag >= SUM_BITS'(tol_model));
    open_poly = 1'b0;
  endfunction

  function automatic vertex_t vtx(input longint qx, input longint qy, input longint vx,
                                  input longint vy, input bit last);
    vertex_t v;
    v.qx = COORD_BITS'(qx);
    v.qy = COORD_BITS'(qy);
    v.vx = COORD_BITS'(vx);
    v.vy = COORD_BITS'(vy);
    v.last = last;
    return v;
  endfunction

  function automatic plan_row_t row(input longint qx, input longint qy, input longint vx,
                                    input longint vy, input bit last, input bit typed = 1'b0,
                                    input bit ins = 1'b0, input bit onv = 1'b0);
    plan_row_t r;
    r.v = vtx(qx, qy, vx, vy, last);
    r.typed = typed;
    r.want.in_poly = ins;
    r.want.on_vtx = onv;
    return r;
  endfunction

  function automatic void plan_add(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic longint any_coord();
    if ($urandom_range(1))
      return longint'(int'($urandom));
    return longint'($urandom_range(0, 200)) - 100;
  endfunction

  task automatic send_vertex(input vertex_t v, input bit typed, input verdict_t want);
    bit       closed;
    verdict_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    query_x <= v.qx;
    query_y <= v.qy;
    vertex_x <= v.vx;
    vertex_y <= v.vy;
    last_vertex <= v.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    fold_vertex(v, closed, res);
    if (closed)
      verdicts_due.insert(verdicts_due.size(), typed ? want : res);
  endtask

  task automatic send_ring(input int turns, input bit on_corner);
    longint lim;
    longint cx;
    longint cy;
    longint r;
    longint qx;
    longint qy;
    longint px;
    longint py;
    int     n;
    int     total;
    int     pick;
    int     k;
    real    phase;
    real    pitch;
    lim = ($urandom_range(3) == 0) ? 64'sd1073741824 : 64'sd1000;
    r = (lim > 1000) ? longint'($urandom_range(4, 1 << 28)) : longint'($urandom_range(4, 500));
    cx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    cy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    n = $urandom_range(3, 8);
    total = n * turns;
    phase = $urandom_range(0, 6283) / 1000.0;
    pitch = 2.0 * PI / n * ($urandom_range(1) ? 1.0 : -1.0);
    case ($urandom_range(3))
      0, 1: begin
        qx = cx + longint'($urandom_range(0, 32'(r / 2))) - r / 4;
        qy = cy + longint'($urandom_range(0, 32'(r / 2))) - r / 4;
      end
      2: begin
        qx = cx + 3 * r;
        qy = cy;
      end
      default: begin
        qx = longint'(int'($urandom));
        qy = longint'(int'($urandom));
      end
    endcase
    if (on_corner) begin
      pick = $urandom_range(0, total - 1);
      qx = cx + longint'($rtoi(r * $cos(phase + pitch * pick)));
      qy = cy + longint'($rtoi(r * $sin(phase + pitch * pick)));
    end
    for (k = 0; k < total; k++) begin
      px = cx + longint'($rtoi(r * $cos(phase + pitch * k)));
      py = cy + longint'($rtoi(r * $sin(phase + pitch * k)));
      send_vertex(vtx(qx, qy, px, py, k == total - 1), 1'b0, '0);
    end
  endtask

  // vertices alternate across the point: each non-closing step is exactly a half turn
  task automatic send_spin(input int n);
    longint qx;
    longint qy;
    int     k;
    qx = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd1073741824;
    qy = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd1073741824;
    for (k = 0; k < n; k++)
      send_vertex(vtx(qx, qy, (k % 2) ? qx - 10 : qx + 10, qy, k == n - 1), 1'b0, '0);
  endtask

  // unstructured vertices, moving point, stray closing marks
  task automatic send_scatter();
    longint qx;
    longint qy;
    longint px;
    longint py;
    int     n;
    int     k;
    n = $urandom_range(1, 6);
    qx = any_coord();
    qy = any_coord();
    for (k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        qx = any_coord();
        qy = any_coord();
      end
      px = any_coord();
      py = any_coord();
      if ($urandom_range(5) == 0) begin
        px = qx;
        py = qy;
      end
      send_vertex(vtx(qx, qy, px, py, (k == n - 1) || ($urandom_range(7) == 0)), 1'b0, '0);
    end
  endtask

  task automatic send_polygons(input int count);
    int stop;
    int pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55)
        send_ring(1, 1'b0);
      else if (pick < 65)
        send_ring(1, 1'b1);
      else if (pick < 75)
        send_ring($urandom_range(2, 4), 1'b0);
      else
        send_scatter();
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_BITS-1:0] t);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_model = t;
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (inside_res !== want.in_poly) begin
          $error("inside_res: expected %0d, got %0d", want.in_poly, inside_res);
          errors++;
        end
        if (on_vertex !== want.on_vtx) begin
          $error("on_vertex: expected %0d, got %0d", want.on_vtx, on_vertex);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      cycles_quiet <= 0;
    else
      cycles_quiet <= cycles_quiet + 1;
    if (cycles_quiet >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int i;
    // single-vertex polygons, point off and on the vertex
    plan_add(row(5, 5, 0, 0, 1, 1'b1, 1'b0, 1'b0));
    plan_add(row(7, -3, 7, -3, 1, 1'b1, 1'b0, 1'b1));
    plan_add(row(CMAX, CMAX, CMAX, CMAX, 1, 1'b1, 1'b0, 1'b1));
    // square around the point, then square missing it
    plan_add(row(0, 0, 10, 10, 0));
    plan_add(row(0, 0, -10, 10, 0));
    plan_add(row(0, 0, -10, -10, 0));
    plan_add(row(0, 0, 10, -10, 1));
    plan_add(row(100, 0, 10, 10, 0));
    plan_add(row(100, 0, 10, -10, 0));
    plan_add(row(100, 0, -10, -10, 0));
    plan_add(row(100, 0, -10, 10, 1));
    // full-range coordinates
    plan_add(row(0, 0, CMAX, CMAX, 0));
    plan_add(row(0, 0, CMIN, CMAX, 0));
    plan_add(row(0, 0, CMIN, CMIN, 0));
    plan_add(row(0, 0, CMAX, CMIN, 1));
    plan_add(row(CMIN, CMIN, CMAX, CMIN, 0));
    plan_add(row(CMIN, CMIN, CMAX, CMAX, 0));
    plan_add(row(CMIN, CMIN, CMIN, CMAX, 1));
    // point on a vertex inside a triangle
    plan_add(row(3, 4, 0, 0, 0));
    plan_add(row(3, 4, 3, 4, 0));
    plan_add(row(3, 4, 6, 0, 1, 1'b1, 1'b0, 1'b1));
    // point moving within a polygon
    plan_add(row(1, 1, 5, 0, 0));
    plan_add(row(-1, -1, 0, 5, 1));
    // exact half-turn steps
    plan_add(row(0, 0, 10, 0, 0));
    plan_add(row(0, 0, -10, 0, 1));

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    query_x <= '0;
    query_y <= '0;
    vertex_x <= '0;
    vertex_y <= '0;
    last_vertex <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++)
      send_vertex(plan[i].v, plan[i].typed, plan[i].want);

    settle_idle();
    set_tolerance('0);
    send_polygons(300);

    // accumulator reaching the sign bit, then wrapping to zero
    settle_idle();
    set_tolerance('1);
    send_polygons(200);
    send_spin(256);
    send_spin(512);
    send_spin($urandom_range(2, 40));

    // long output hold-off while closing vertices keep coming
    settle_idle();
    set_tolerance(TOL_BITS'(1));
    hold_req = 1'b1;
    repeat (30)
      send_vertex(vtx(any_coord(), any_coord(), any_coord(), any_coord(), 1'b1), 1'b0, '0);

    settle_idle();
    set_tolerance(TOL_BITS'($urandom_range(2, 32766)));
    steady = 1'b1;
    send_polygons(400);
    steady = 1'b0;

    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      set_tolerance($urandom_range(1) ? TOL_RESET : TOL_BITS'($urandom));
      send_polygons(300);
    end

    settle_idle();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
